[rtl/cpu_bus_memory_map_with_stack_unit_defines.svh]
// Assertion macros shared by the checker of the CPU bus memory map.
`ifndef CPU_BUS_MEMORY_MAP_WITH_STACK_UNIT_DEFINES_SVH
`define CPU_BUS_MEMORY_MAP_WITH_STACK_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CBMMS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CBMMS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/cbmms_pkg.sv]
// Types and fixed constants of the CPU bus memory map.
package cbmms_pkg;

	typedef enum logic [1:0] {
		MODE_READ  = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_PUSH  = 2'd2,
		MODE_POP   = 2'd3
	} mode_t;

	localparam logic [15:0] PIC_BASE   = 16'h2000;
	localparam logic [15:0] AUDIO_BASE = 16'h4000;
	localparam logic [15:0] STACK_PAGE = 16'h0100;

	localparam int PIC_REG_COUNT = 8;
	localparam int PIC_IW        = $clog2(PIC_REG_COUNT);

endpackage

[rtl/cpu_bus_memory_map_with_stack_unit.sv]
// CPU bus memory map: internal RAM, picture and audio registers, stack push and pop.
// Path: an accepted request waits in stage 1, then in the output register on m_axis.
// Throughput: one request per cycle unless m_axis stalls; the single-port synchronous
// RAM's read fills stage 1, and a write lands before the next request reads.
// Reset (arst_n low, asynchronous) empties stage 1 and the output register only;
// RAM, picture and audio registers hold no reset value and are valid once written.
module cpu_bus_memory_map_with_stack_unit #(
	parameter int RAM_BYTES       = 2048,
	parameter int AUDIO_REG_COUNT = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// request side
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [31:0]           s_axis_tdata,  // bus_address[15:0], write_data[23:16],
	                                             // stack_pointer[31:24]
	input  cbmms_pkg::mode_t      s_axis_tuser,  // mode[1:0]
	// result side
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [15:0]           m_axis_tdata,  // read_data[7:0], new_stack_pointer[15:8]
	output logic                  m_axis_tuser   // out_of_range[0]
);
	import cbmms_pkg::*;

	localparam int RAM_IW = $clog2(RAM_BYTES);
	localparam int AUD_IW = $clog2(AUDIO_REG_COUNT);
	// how many whole RAM images fit below the picture window (mirror folds)
	localparam int FOLDS  = 32'(PIC_BASE) / RAM_BYTES;

	// request fields
	logic [15:0] bus_address;
	logic [7:0]  write_data;
	logic [7:0]  stack_pointer;
	mode_t       mode;
	logic        req_acc;

	assign bus_address   = s_axis_tdata[15:0];
	assign write_data    = s_axis_tdata[23:16];
	assign stack_pointer = s_axis_tdata[31:24];
	assign mode          = s_axis_tuser;

	// region decode
	logic              hit_ram, hit_pic, hit_aud, oor;
	logic [15:0]       aud_off;
	logic [AUD_IW-1:0] aud_idx;
	logic [PIC_IW-1:0] pic_idx;

	assign hit_ram = bus_address < PIC_BASE;
	assign hit_pic = !hit_ram && (bus_address < AUDIO_BASE);
	assign aud_off = bus_address - AUDIO_BASE;
	assign hit_aud = (bus_address >= AUDIO_BASE) && (aud_off < 16'(AUDIO_REG_COUNT));
	assign oor     = (bus_address >= AUDIO_BASE) && !hit_aud;
	assign aud_idx = aud_off[AUD_IW-1:0];
	assign pic_idx = bus_address[PIC_IW-1:0];

	// RAM mirroring: subtract the largest multiple of RAM_BYTES not above the address.
	// Each fold compares against its own constant, so the folds are independent.
	logic [RAM_IW-1:0] bus_idx;
	always_comb begin
		logic [15:0] fold_base;
		bus_idx = RAM_IW'(bus_address);
		for (int k = 1; k <= FOLDS; k++) begin
			fold_base = 16'(k * RAM_BYTES);
			if (bus_address >= fold_base) begin
				bus_idx = RAM_IW'(bus_address - fold_base);
			end
		end
	end

	// stack: push uses SP, pop uses SP+1, both within page 0x100
	logic [7:0]        sp_pop;
	logic [7:0]        sp_eff;
	logic [15:0]       stack_addr;
	logic [RAM_IW-1:0] stack_idx;
	logic [7:0]        new_sp;

	assign sp_pop     = stack_pointer + 8'd1;
	assign sp_eff     = (mode == MODE_POP) ? sp_pop : stack_pointer;
	assign stack_addr = STACK_PAGE + {8'd0, sp_eff};
	assign stack_idx  = RAM_IW'(stack_addr);

	always_comb begin
		unique case (mode)
			MODE_READ:  new_sp = stack_pointer;
			MODE_WRITE: new_sp = stack_pointer;
			MODE_PUSH:  new_sp = stack_pointer - 8'd1;
			MODE_POP:   new_sp = sp_pop;
			default:    new_sp = stack_pointer;
		endcase
	end

	// RAM port control: one address per request, read or write
	logic              is_stack;
	logic [RAM_IW-1:0] ram_idx;
	logic              ram_we, ram_re;

	assign is_stack = (mode == MODE_PUSH) || (mode == MODE_POP);
	assign ram_idx  = is_stack ? stack_idx : bus_idx;
	assign ram_we   = req_acc && ((mode == MODE_PUSH) || ((mode == MODE_WRITE) && hit_ram));
	assign ram_re   = (mode == MODE_POP) || ((mode == MODE_READ) && hit_ram);

	// register-file stores
	logic [7:0] pic_regs_q [PIC_REG_COUNT];
	logic [7:0] aud_regs_q [AUDIO_REG_COUNT];
	logic [7:0] reg_rd;

	always_comb begin
		priority if ((mode == MODE_READ) && hit_pic) begin
			reg_rd = pic_regs_q[pic_idx];
		end else if ((mode == MODE_READ) && hit_aud) begin
			reg_rd = aud_regs_q[aud_idx];
		end else begin
			reg_rd = 8'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc && (mode == MODE_WRITE) && hit_pic) begin
			pic_regs_q[pic_idx] <= write_data;
		end
		if (req_acc && (mode == MODE_WRITE) && hit_aud) begin
			aud_regs_q[aud_idx] <= write_data;
		end
	end

	// internal RAM, synchronous read into stage 1
	logic [7:0] ram_mem [RAM_BYTES];
	logic [7:0] ram_rd_s1;

	always_ff @(posedge clk) begin
		if (ram_we) begin
			ram_mem[ram_idx] <= write_data;
		end
		if (req_acc) begin
			ram_rd_s1 <= ram_mem[ram_idx];
		end
	end

	// stage 1: request waiting for RAM data
	logic       v_s1;
	logic       use_ram_s1;
	logic [7:0] reg_rd_s1;
	logic [7:0] new_sp_s1;
	logic       oor_s1;
	logic       s1_move;
	logic       out_v_q;

	assign s1_move       = v_s1 && (!out_v_q || m_axis_tready);
	assign s_axis_tready = !v_s1 || s1_move;
	assign req_acc       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req_acc) begin
			v_s1 <= 1'b1;
		end else if (s1_move) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			use_ram_s1 <= ram_re;
			reg_rd_s1  <= reg_rd;
			new_sp_s1  <= new_sp;
			oor_s1     <= oor && !is_stack;
		end
	end

	// output register: a finished result waits here while stage 1 takes the next request
	logic [15:0] out_data_q;
	logic        out_oor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_move) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_data_q <= {new_sp_s1, use_ram_s1 ? ram_rd_s1 : reg_rd_s1};
			out_oor_q  <= oor_s1;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_oor_q;

endmodule

[rtl/cbmms_checker.sv]
// Port-level checker of the CPU bus memory map, bound to the top level.
`include "cpu_bus_memory_map_with_stack_unit_defines.svh"

module cbmms_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic [31:0]           s_axis_tdata,
	input cbmms_pkg::mode_t      s_axis_tuser,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [15:0]           m_axis_tdata,
	input logic                  m_axis_tuser
);
	import cbmms_pkg::*;

	// stalled result stays offered unchanged
	`CBMMS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
		"stalled result changed or dropped")

	// a draining output never blocks requests
	`CBMMS_ASSERT_NOW(a_ready_when_drained, m_axis_tready, s_axis_tready,
		"request stalled while result side is ready")

	// push: no read data, SP drops by one, no range flag
	`CBMMS_ASSERT_NEXT(a_push_result,
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_PUSH) ##1 m_axis_tready,
		m_axis_tvalid && (m_axis_tdata[7:0] == 8'd0) &&
		(m_axis_tdata[15:8] == $past(s_axis_tdata[31:24], 2) - 8'd1) && !m_axis_tuser,
		"push result wrong")

	// write: no read data, SP unchanged
	`CBMMS_ASSERT_NEXT(a_write_result,
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_WRITE) ##1 m_axis_tready,
		m_axis_tvalid && (m_axis_tdata[7:0] == 8'd0) &&
		(m_axis_tdata[15:8] == $past(s_axis_tdata[31:24], 2)),
		"write result wrong")

endmodule

bind cpu_bus_memory_map_with_stack_unit cbmms_checker u_cbmms_checker (.*);
